// ===== design/cup_pkg.sv =====
// ----------------------------------------------------------------------------
// cup_pkg
// Shared types, sizes and codes of the CNF unit propagation engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cup_pkg;

    localparam int MAX_VARS     = 1024;
    localparam int MAX_CLAUSES  = 4096;
    localparam int MAX_LITERALS = 16384;

    localparam int VW  = 10;  // variable index
    localparam int LCW = 15;  // literal count / literal pointer
    localparam int LAW = 14;  // literal store address
    localparam int CCW = 13;  // clause count
    localparam int CIW = 12;  // clause index
    localparam int QCW = 11;  // queue fill

    localparam logic [2:0] K_LOAD   = 3'd0;
    localparam logic [2:0] K_SEAL   = 3'd1;
    localparam logic [2:0] K_UNITS  = 3'd2;
    localparam logic [2:0] K_ASSIGN = 3'd3;
    localparam logic [2:0] K_READ   = 3'd4;

    localparam logic [1:0] V_UNDEF = 2'd0;
    localparam logic [1:0] V_TRUE  = 2'd1;
    localparam logic [1:0] V_FALSE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]    kind;
        logic [VW-1:0] var_index;
        logic          negated;
        logic          clause_end;
        logic          in_range;
    } t_cmd;

    typedef struct packed {
        logic take;      // back end pops the head command this cycle
        logic clearing;  // power-up clearing pass running
    } t_back_stat;

endpackage

`default_nettype wire

// ===== design/cup_ram.sv =====
// ----------------------------------------------------------------------------
// cup_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cup_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] mem [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/cup_front.sv =====
// ----------------------------------------------------------------------------
// cup_front
// Command intake: range check against var_count, two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cup_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [2:0]            i_kind,
    input  wire logic [cup_pkg::VW-1:0] i_var_index,
    input  wire logic                  i_negated,
    input  wire logic                  i_clause_end,
    input  wire logic                  i_cfg_valid,
    input  wire logic [cup_pkg::VW-1:0] i_cfg_data,
    input  wire cup_pkg::t_back_stat   i_back,
    output logic                       o_busy,
    output logic                       o_cfg_ready,
    output logic                       o_cmd_valid,
    output cup_pkg::t_cmd              o_cmd
);
    import cup_pkg::*;

    logic [VW-1:0] r_var_count;
    t_cmd          r_q [0:1];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    t_cmd          cmd_in;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_cnt == 2'd2) || i_back.clearing;
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.kind       = i_kind;
        cmd_in.var_index  = i_var_index;
        cmd_in.negated    = i_negated;
        cmd_in.clause_end = i_clause_end;
        cmd_in.in_range   = (i_var_index != '0) && (i_var_index <= r_var_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_count <= VW'(MAX_VARS - 1);
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                r_var_count <= i_cfg_data;
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_back.take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_back.take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== design/cup_back.sv =====
// ----------------------------------------------------------------------------
// cup_back
// Execution sequencer: clause store, occurrence lists, propagation walk.
// ----------------------------------------------------------------------------
`default_nettype none

module cup_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cmd_valid,
    input  wire cup_pkg::t_cmd          i_cmd,
    output cup_pkg::t_back_stat         o_stat,
    output logic                        o_done,
    output logic                        o_conflict,
    output logic [cup_pkg::CCW-1:0]     o_unsat_clauses,
    output logic [1:0]                  o_var_state,
    output logic [cup_pkg::CIW-1:0]     o_last_clause,
    output logic [1:0]                  o_status
);
    import cup_pkg::*;

    localparam logic [5:0] S_CLR    = 6'd0;
    localparam logic [5:0] S_IDLE   = 6'd1;
    localparam logic [5:0] S_FIN    = 6'd2;
    localparam logic [5:0] S_OUT    = 6'd3;
    localparam logic [5:0] S_CNT_RD = 6'd4;
    localparam logic [5:0] S_CNT_LW = 6'd5;
    localparam logic [5:0] S_CNT_FW = 6'd6;
    localparam logic [5:0] S_PRE_RD = 6'd7;
    localparam logic [5:0] S_PRE_WR = 6'd8;
    localparam logic [5:0] S_SC_CLS = 6'd9;
    localparam logic [5:0] S_SC_CLW = 6'd10;
    localparam logic [5:0] S_SC_LRD = 6'd11;
    localparam logic [5:0] S_SC_LW  = 6'd12;
    localparam logic [5:0] S_SC_LP  = 6'd13;
    localparam logic [5:0] S_IN_C   = 6'd14;
    localparam logic [5:0] S_IN_CW  = 6'd15;
    localparam logic [5:0] S_IN_LW  = 6'd16;
    localparam logic [5:0] S_IN_VW  = 6'd17;
    localparam logic [5:0] S_AS_VW  = 6'd18;
    localparam logic [5:0] S_P_POP  = 6'd19;
    localparam logic [5:0] S_P_QW   = 6'd20;
    localparam logic [5:0] S_P_VW   = 6'd21;
    localparam logic [5:0] S_P_S0   = 6'd22;
    localparam logic [5:0] S_P_S1   = 6'd23;
    localparam logic [5:0] S_P_SAT  = 6'd24;
    localparam logic [5:0] S_P_SATW = 6'd25;
    localparam logic [5:0] S_P_SATA = 6'd26;
    localparam logic [5:0] S_P_DEC  = 6'd27;
    localparam logic [5:0] S_P_DECW = 6'd28;
    localparam logic [5:0] S_P_DECA = 6'd29;
    localparam logic [5:0] S_F_0    = 6'd30;
    localparam logic [5:0] S_F_1    = 6'd31;
    localparam logic [5:0] S_F_2    = 6'd32;
    localparam logic [5:0] S_F_L    = 6'd33;
    localparam logic [5:0] S_F_LW   = 6'd34;
    localparam logic [5:0] S_F_VW   = 6'd35;
    localparam logic [5:0] S_CNT_CL = 6'd36;

    // memory ports
    logic           lit_we;  logic [LAW-1:0] lit_wa, lit_ra; logic [VW:0]    lit_wd, lit_rd;
    logic           cs_we;   logic [CCW-1:0] cs_wa, cs_ra;   logic [LCW-1:0] cs_wd, cs_rd;
    logic           act_we;  logic [CIW-1:0] act_wa, act_ra; logic [LCW-1:0] act_wd, act_rd;
    logic           var_we;  logic [VW-1:0]  var_wa, var_ra; logic [1:0]     var_wd, var_rd;
    logic           ps_we;   logic [VW:0]    ps_wa, ps_ra;   logic [LCW-1:0] ps_wd, ps_rd;
    logic           ns_we;   logic [VW:0]    ns_wa, ns_ra;   logic [LCW-1:0] ns_wd, ns_rd;
    logic           pf_we;   logic [VW-1:0]  pf_wa, pf_ra;   logic [LCW-1:0] pf_wd, pf_rd;
    logic           nf_we;   logic [VW-1:0]  nf_wa, nf_ra;   logic [LCW-1:0] nf_wd, nf_rd;
    logic           pl_we;   logic [LAW-1:0] pl_wa, pl_ra;   logic [CIW-1:0] pl_wd, pl_rd;
    logic           nl_we;   logic [LAW-1:0] nl_wa, nl_ra;   logic [CIW-1:0] nl_wd, nl_rd;
    logic           q_we;    logic [VW-1:0]  q_wa, q_ra;     logic [VW-1:0]  q_wd, q_rd;

    cup_ram #(.W(VW+1), .D(MAX_LITERALS)) u_lit (.i_clk, .i_we(lit_we), .i_waddr(lit_wa),
        .i_wdata(lit_wd), .i_raddr(lit_ra), .o_rdata(lit_rd));
    cup_ram #(.W(LCW), .D(MAX_CLAUSES+1)) u_cs (.i_clk, .i_we(cs_we), .i_waddr(cs_wa),
        .i_wdata(cs_wd), .i_raddr(cs_ra), .o_rdata(cs_rd));
    cup_ram #(.W(LCW), .D(MAX_CLAUSES)) u_act (.i_clk, .i_we(act_we), .i_waddr(act_wa),
        .i_wdata(act_wd), .i_raddr(act_ra), .o_rdata(act_rd));
    cup_ram #(.W(2), .D(MAX_VARS)) u_var (.i_clk, .i_we(var_we), .i_waddr(var_wa),
        .i_wdata(var_wd), .i_raddr(var_ra), .o_rdata(var_rd));
    cup_ram #(.W(LCW), .D(MAX_VARS+1)) u_ps (.i_clk, .i_we(ps_we), .i_waddr(ps_wa),
        .i_wdata(ps_wd), .i_raddr(ps_ra), .o_rdata(ps_rd));
    cup_ram #(.W(LCW), .D(MAX_VARS+1)) u_ns (.i_clk, .i_we(ns_we), .i_waddr(ns_wa),
        .i_wdata(ns_wd), .i_raddr(ns_ra), .o_rdata(ns_rd));
    cup_ram #(.W(LCW), .D(MAX_VARS)) u_pf (.i_clk, .i_we(pf_we), .i_waddr(pf_wa),
        .i_wdata(pf_wd), .i_raddr(pf_ra), .o_rdata(pf_rd));
    cup_ram #(.W(LCW), .D(MAX_VARS)) u_nf (.i_clk, .i_we(nf_we), .i_waddr(nf_wa),
        .i_wdata(nf_wd), .i_raddr(nf_ra), .o_rdata(nf_rd));
    cup_ram #(.W(CIW), .D(MAX_LITERALS)) u_pl (.i_clk, .i_we(pl_we), .i_waddr(pl_wa),
        .i_wdata(pl_wd), .i_raddr(pl_ra), .o_rdata(pl_rd));
    cup_ram #(.W(CIW), .D(MAX_LITERALS)) u_nl (.i_clk, .i_we(nl_we), .i_waddr(nl_wa),
        .i_wdata(nl_wd), .i_raddr(nl_ra), .o_rdata(nl_rd));
    cup_ram #(.W(VW), .D(MAX_VARS)) u_q (.i_clk, .i_we(q_we), .i_waddr(q_wa),
        .i_wdata(q_wd), .i_raddr(q_ra), .o_rdata(q_rd));

    logic [5:0]     r_state, n_state;
    t_cmd           r_cmd, n_cmd;
    logic [LCW-1:0] r_lits, n_lits;
    logic [CCW-1:0] r_clauses, n_clauses;
    logic [LCW-1:0] r_end_lits, n_end_lits;
    logic [CCW-1:0] r_unsat, n_unsat;
    logic [CIW-1:0] r_last, n_last;
    logic [QCW-1:0] r_qtop, n_qtop;
    logic           r_conf, n_conf;
    logic [1:0]     r_stat, n_stat;
    logic [VW:0]    r_clr, n_clr;
    logic [VW:0]    r_pv, n_pv;
    logic [LCW-1:0] r_i, n_i;
    logic [LCW-1:0] r_e, n_e;
    logic [CCW-1:0] r_c, n_c;
    logic [VW-1:0]  r_v, n_v;
    logic           r_neg, n_neg;
    logic           r_sel, n_sel;
    logic [LCW-1:0] r_sp, n_sp, r_sn, n_sn;
    logic [LCW-1:0] r_pa, n_pa, r_na, n_na;
    logic [LCW-1:0] r_da, n_da, r_db, n_db;
    logic [CIW-1:0] r_pc, n_pc;
    logic [LCW-1:0] r_j, n_j, r_fb, n_fb;

    logic [VW-1:0]  lit_v;
    logic           lit_n;
    logic [1:0]     want;
    logic [LCW:0]   sc_p;
    logic [LCW-1:0] act_dec;
    logic [CCW-1:0] unsat_dec;
    logic [CIW-1:0] list_c;

    assign lit_v     = lit_rd[VW:1];
    assign lit_n     = lit_rd[0];
    assign want      = r_neg ? V_FALSE : V_TRUE;
    assign act_dec   = act_rd - LCW'(1);
    assign unsat_dec = (r_unsat != '0) ? (r_unsat - CCW'(1)) : r_unsat;
    assign sc_p      = r_neg ? ({1'b0, ns_rd} + {1'b0, nf_rd}) : ({1'b0, ps_rd} + {1'b0, pf_rd});

    assign o_stat.take     = (r_state == S_IDLE) && i_cmd_valid;
    assign o_stat.clearing = (r_state == S_CLR);

    assign o_done          = (r_state == S_OUT);
    assign o_conflict      = r_conf;
    assign o_unsat_clauses = r_unsat;
    assign o_var_state     = r_cmd.in_range ? var_rd : V_UNDEF;
    assign o_last_clause   = r_last;
    assign o_status        = r_stat;

    always_comb begin
        n_state = r_state;  n_cmd = r_cmd;  n_lits = r_lits;  n_clauses = r_clauses;
        n_end_lits = r_end_lits;  n_unsat = r_unsat;  n_last = r_last;  n_qtop = r_qtop;
        n_conf = r_conf;  n_stat = r_stat;  n_clr = r_clr;  n_pv = r_pv;  n_i = r_i;
        n_e = r_e;  n_c = r_c;  n_v = r_v;  n_neg = r_neg;  n_sel = r_sel;  n_sp = r_sp;
        n_sn = r_sn;  n_pa = r_pa;  n_na = r_na;  n_da = r_da;  n_db = r_db;  n_pc = r_pc;
        n_j = r_j;  n_fb = r_fb;
        list_c = '0;

        lit_we = 1'b0; lit_wa = '0; lit_wd = '0; lit_ra = '0;
        cs_we  = 1'b0; cs_wa  = '0; cs_wd  = '0; cs_ra  = '0;
        act_we = 1'b0; act_wa = '0; act_wd = '0; act_ra = '0;
        var_we = 1'b0; var_wa = '0; var_wd = '0; var_ra = '0;
        ps_we  = 1'b0; ps_wa  = '0; ps_wd  = '0; ps_ra  = '0;
        ns_we  = 1'b0; ns_wa  = '0; ns_wd  = '0; ns_ra  = '0;
        pf_we  = 1'b0; pf_wa  = '0; pf_wd  = '0; pf_ra  = '0;
        nf_we  = 1'b0; nf_wa  = '0; nf_wd  = '0; nf_ra  = '0;
        pl_we  = 1'b0; pl_wa  = '0; pl_wd  = '0; pl_ra  = '0;
        nl_we  = 1'b0; nl_wa  = '0; nl_wd  = '0; nl_ra  = '0;
        q_we   = 1'b0; q_wa   = '0; q_wd   = '0; q_ra   = '0;

        case (r_state)
            S_CLR: begin
                ps_we = 1'b1; ps_wa = r_clr;
                ns_we = 1'b1; ns_wa = r_clr;
                if (!r_clr[VW]) begin
                    var_we = 1'b1; var_wa = r_clr[VW-1:0]; var_wd = V_UNDEF;
                    pf_we  = 1'b1; pf_wa  = r_clr[VW-1:0];
                    nf_we  = 1'b1; nf_wa  = r_clr[VW-1:0];
                    n_clr  = r_clr + (VW+1)'(1);
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd  = i_cmd;
                    n_conf = 1'b0;
                    n_stat = ST_OK;
                    n_state = S_FIN;
                    case (i_cmd.kind)
                        K_LOAD: begin
                            if (!i_cmd.in_range) begin
                                n_stat = ST_RANGE;
                            end else if (r_lits[LAW] ||
                                         (i_cmd.clause_end && r_clauses[CIW])) begin
                                n_stat = ST_FULL;
                            end else begin
                                lit_we = 1'b1; lit_wa = r_lits[LAW-1:0];
                                lit_wd = {i_cmd.var_index, i_cmd.negated};
                                n_lits = r_lits + LCW'(1);
                                if (i_cmd.clause_end) begin
                                    cs_we = 1'b1; cs_wa = r_clauses + CCW'(1);
                                    cs_wd = r_lits + LCW'(1);
                                    n_clauses  = r_clauses + CCW'(1);
                                    n_end_lits = r_lits + LCW'(1);
                                end
                            end
                        end
                        K_SEAL: begin
                            n_pv = '0;
                            n_state = S_CNT_CL;
                        end
                        K_UNITS: begin
                            n_qtop = '0;
                            n_c = '0;
                            n_state = S_IN_C;
                        end
                        K_ASSIGN: begin
                            if (!i_cmd.in_range) begin
                                n_stat = ST_RANGE;
                            end else begin
                                var_ra = i_cmd.var_index;
                                n_v = i_cmd.var_index;
                                n_neg = i_cmd.negated;
                                n_state = S_AS_VW;
                            end
                        end
                        K_READ: begin
                            if (!i_cmd.in_range) n_stat = ST_RANGE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIN: begin
                var_ra = r_cmd.var_index;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end

            // seal: zero the fill counters left over by an earlier scatter
            S_CNT_CL: begin
                if (r_pv[VW]) begin
                    n_i = '0;
                    n_state = S_CNT_RD;
                end else begin
                    pf_we = 1'b1; pf_wa = r_pv[VW-1:0];
                    nf_we = 1'b1; nf_wa = r_pv[VW-1:0];
                    n_pv = r_pv + (VW+1)'(1);
                end
            end
            // seal: count occurrences
            S_CNT_RD: begin
                if (r_i == r_end_lits) begin
                    n_pv = '0; n_sp = '0; n_sn = '0;
                    n_state = S_PRE_RD;
                end else begin
                    lit_ra = r_i[LAW-1:0];
                    n_state = S_CNT_LW;
                end
            end
            S_CNT_LW: begin
                pf_ra = lit_v; nf_ra = lit_v;
                n_v = lit_v; n_neg = lit_n;
                n_state = S_CNT_FW;
            end
            S_CNT_FW: begin
                if (r_neg) begin
                    nf_we = 1'b1; nf_wa = r_v; nf_wd = nf_rd + LCW'(1);
                end else begin
                    pf_we = 1'b1; pf_wa = r_v; pf_wd = pf_rd + LCW'(1);
                end
                n_i = r_i + LCW'(1);
                n_state = S_CNT_RD;
            end
            // seal: list starts, fill and value clear
            S_PRE_RD: begin
                if (r_pv[VW]) begin
                    ps_we = 1'b1; ps_wa = r_pv; ps_wd = r_sp;
                    ns_we = 1'b1; ns_wa = r_pv; ns_wd = r_sn;
                    n_c = '0; n_i = '0;
                    n_state = S_SC_CLS;
                end else begin
                    pf_ra = r_pv[VW-1:0]; nf_ra = r_pv[VW-1:0];
                    n_state = S_PRE_WR;
                end
            end
            S_PRE_WR: begin
                ps_we = 1'b1; ps_wa = r_pv; ps_wd = r_sp;
                ns_we = 1'b1; ns_wa = r_pv; ns_wd = r_sn;
                pf_we = 1'b1; pf_wa = r_pv[VW-1:0];
                nf_we = 1'b1; nf_wa = r_pv[VW-1:0];
                var_we = 1'b1; var_wa = r_pv[VW-1:0]; var_wd = V_UNDEF;
                if (r_pv != '0) begin
                    n_sp = r_sp + pf_rd;
                    n_sn = r_sn + nf_rd;
                end
                n_pv = r_pv + (VW+1)'(1);
                n_state = S_PRE_RD;
            end
            // seal: scatter clause numbers into the lists
            S_SC_CLS: begin
                if (r_c == r_clauses) begin
                    n_unsat = r_clauses;
                    n_qtop = '0;
                    n_last = '0;
                    n_state = S_FIN;
                end else begin
                    cs_ra = r_c + CCW'(1);
                    n_state = S_SC_CLW;
                end
            end
            S_SC_CLW: begin
                n_e = cs_rd;
                act_we = 1'b1; act_wa = r_c[CIW-1:0]; act_wd = cs_rd - r_i;
                n_state = S_SC_LRD;
            end
            S_SC_LRD: begin
                if (r_i == r_e) begin
                    n_c = r_c + CCW'(1);
                    n_state = S_SC_CLS;
                end else begin
                    lit_ra = r_i[LAW-1:0];
                    n_state = S_SC_LW;
                end
            end
            S_SC_LW: begin
                ps_ra = {1'b0, lit_v}; ns_ra = {1'b0, lit_v};
                pf_ra = lit_v; nf_ra = lit_v;
                n_v = lit_v; n_neg = lit_n;
                n_state = S_SC_LP;
            end
            S_SC_LP: begin
                if (r_neg) begin
                    nf_we = 1'b1; nf_wa = r_v; nf_wd = nf_rd + LCW'(1);
                    if (sc_p[LCW:LAW] == '0) begin
                        nl_we = 1'b1; nl_wa = sc_p[LAW-1:0]; nl_wd = r_c[CIW-1:0];
                    end
                end else begin
                    pf_we = 1'b1; pf_wa = r_v; pf_wd = pf_rd + LCW'(1);
                    if (sc_p[LCW:LAW] == '0) begin
                        pl_we = 1'b1; pl_wa = sc_p[LAW-1:0]; pl_wd = r_c[CIW-1:0];
                    end
                end
                n_i = r_i + LCW'(1);
                n_state = S_SC_LRD;
            end

            // initial unit clauses
            S_IN_C: begin
                if (r_c == r_clauses) begin
                    n_state = S_P_POP;
                end else begin
                    act_ra = r_c[CIW-1:0];
                    cs_ra = r_c;
                    n_state = S_IN_CW;
                end
            end
            S_IN_CW: begin
                if (act_rd != LCW'(1)) begin
                    n_c = r_c + CCW'(1);
                    n_state = S_IN_C;
                end else begin
                    lit_ra = (r_c == '0) ? '0 : cs_rd[LAW-1:0];
                    n_state = S_IN_LW;
                end
            end
            S_IN_LW: begin
                var_ra = lit_v;
                n_v = lit_v; n_neg = lit_n;
                n_state = S_IN_VW;
            end
            S_IN_VW: begin
                if (var_rd == V_UNDEF) begin
                    var_we = 1'b1; var_wa = r_v; var_wd = want;
                    if (!r_qtop[VW]) begin
                        q_we = 1'b1; q_wa = r_qtop[VW-1:0]; q_wd = r_v;
                        n_qtop = r_qtop + QCW'(1);
                    end
                    n_c = r_c + CCW'(1);
                    n_state = S_IN_C;
                end else if (var_rd != want) begin
                    n_conf = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_c = r_c + CCW'(1);
                    n_state = S_IN_C;
                end
            end

            // assign one variable
            S_AS_VW: begin
                if (var_rd != V_UNDEF) begin
                    n_conf = (var_rd != want);
                    n_state = S_FIN;
                end else begin
                    var_we = 1'b1; var_wa = r_v; var_wd = want;
                    q_we = 1'b1; q_wa = '0; q_wd = r_v;
                    n_qtop = QCW'(1);
                    n_state = S_P_POP;
                end
            end

            // propagation
            S_P_POP: begin
                if (r_qtop == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_qtop = r_qtop - QCW'(1);
                    q_ra = VW'(r_qtop - QCW'(1));
                    n_state = S_P_QW;
                end
            end
            S_P_QW: begin
                var_ra = q_rd;
                n_v = q_rd;
                n_state = S_P_VW;
            end
            S_P_VW: begin
                n_sel = (var_rd == V_TRUE);
                ps_ra = {1'b0, r_v}; ns_ra = {1'b0, r_v};
                n_state = S_P_S0;
            end
            S_P_S0: begin
                n_pa = ps_rd; n_na = ns_rd;
                ps_ra = {1'b0, r_v} + (VW+1)'(1);
                ns_ra = {1'b0, r_v} + (VW+1)'(1);
                n_state = S_P_S1;
            end
            S_P_S1: begin
                if (r_sel) begin
                    n_i = r_pa; n_e = ps_rd; n_da = r_na; n_db = ns_rd;
                end else begin
                    n_i = r_na; n_e = ns_rd; n_da = r_pa; n_db = ps_rd;
                end
                n_state = S_P_SAT;
            end
            S_P_SAT: begin
                if (r_i >= r_e) begin
                    n_i = r_da; n_e = r_db;
                    n_state = S_P_DEC;
                end else begin
                    pl_ra = r_i[LAW-1:0]; nl_ra = r_i[LAW-1:0];
                    n_state = S_P_SATW;
                end
            end
            S_P_SATW: begin
                list_c = r_sel ? pl_rd : nl_rd;
                act_ra = list_c;
                n_pc = list_c;
                n_state = S_P_SATA;
            end
            S_P_SATA: begin
                if (act_rd != '0) n_unsat = unsat_dec;
                act_we = 1'b1; act_wa = r_pc; act_wd = '0;
                n_i = r_i + LCW'(1);
                n_state = S_P_SAT;
            end
            S_P_DEC: begin
                if (r_i >= r_e) begin
                    n_state = S_P_POP;
                end else begin
                    pl_ra = r_i[LAW-1:0]; nl_ra = r_i[LAW-1:0];
                    n_state = S_P_DECW;
                end
            end
            S_P_DECW: begin
                list_c = r_sel ? nl_rd : pl_rd;
                act_ra = list_c;
                n_pc = list_c;
                n_state = S_P_DECA;
            end
            S_P_DECA: begin
                if (act_rd == '0) begin
                    n_i = r_i + LCW'(1);
                    n_state = S_P_DEC;
                end else begin
                    act_we = 1'b1; act_wa = r_pc; act_wd = act_dec;
                    n_last = r_pc;
                    if (act_dec == LCW'(1)) begin
                        n_state = S_F_0;
                    end else begin
                        n_i = r_i + LCW'(1);
                        n_state = S_P_DEC;
                    end
                end
            end

            // force the last open literal of a clause
            S_F_0: begin
                cs_ra = {1'b0, r_pc};
                n_state = S_F_1;
            end
            S_F_1: begin
                n_j = (r_pc == '0) ? '0 : cs_rd;
                cs_ra = {1'b0, r_pc} + CCW'(1);
                n_state = S_F_2;
            end
            S_F_2: begin
                n_fb = cs_rd;
                n_state = S_F_L;
            end
            S_F_L: begin
                if (r_j >= r_fb) begin
                    n_conf = 1'b1;
                    n_state = S_FIN;
                end else begin
                    lit_ra = r_j[LAW-1:0];
                    n_state = S_F_LW;
                end
            end
            S_F_LW: begin
                var_ra = lit_v;
                n_v = lit_v; n_neg = lit_n;
                n_state = S_F_VW;
            end
            S_F_VW: begin
                if ((var_rd == want) || (var_rd == V_UNDEF)) begin
                    if (var_rd == V_UNDEF) begin
                        var_we = 1'b1; var_wa = r_v; var_wd = want;
                        if (!r_qtop[VW]) begin
                            q_we = 1'b1; q_wa = r_qtop[VW-1:0]; q_wd = r_v;
                            n_qtop = r_qtop + QCW'(1);
                        end
                    end
                    n_unsat = unsat_dec;
                    act_we = 1'b1; act_wa = r_pc; act_wd = '0;
                    n_i = r_i + LCW'(1);
                    n_state = S_P_DEC;
                end else begin
                    n_j = r_j + LCW'(1);
                    n_state = S_F_L;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_lits     <= '0;
            r_clauses  <= '0;
            r_end_lits <= '0;
            r_unsat    <= '0;
            r_last     <= '0;
            r_qtop     <= '0;
            r_conf     <= 1'b0;
            r_stat     <= ST_OK;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_lits     <= n_lits;
            r_clauses  <= n_clauses;
            r_end_lits <= n_end_lits;
            r_unsat    <= n_unsat;
            r_last     <= n_last;
            r_qtop     <= n_qtop;
            r_conf     <= n_conf;
            r_stat     <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;  r_pv <= n_pv;  r_i <= n_i;  r_e <= n_e;  r_c <= n_c;
        r_v <= n_v;  r_neg <= n_neg;  r_sel <= n_sel;  r_sp <= n_sp;  r_sn <= n_sn;
        r_pa <= n_pa;  r_na <= n_na;  r_da <= n_da;  r_db <= n_db;  r_pc <= n_pc;
        r_j <= n_j;  r_fb <= n_fb;
    end

endmodule

`default_nettype wire

// ===== design/cnf_unit_propagation.sv =====
// ----------------------------------------------------------------------------
// cnf_unit_propagation
// CNF clause store with occurrence lists and unit propagation sequencer.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+-------------------
//  command   | i_kind i_var_index i_negated i_clause_end      | start & !busy
//  result    | o_conflict o_unsat_clauses o_var_state         | o_done, one cycle
//            | o_last_clause o_status                         |
//  config    | i_cfg_data (var_count)                         | i_cfg_valid & ready
//
//  Sequencing: every command beat yields one result beat. With the sequencer
//  idle, load, read, unknown and out-of-range assign commands pass through
//  the S_FIN and S_OUT states to their result beat. Seal zeroes the fill
//  counters of all 1024 variables, counts the occurrences of each literal,
//  computes list starts per variable, and scatters clause numbers per clause
//  and per literal. Propagation walks the occurrence lists and scans the
//  literals of a clause when it is forced; every step waits on a registered
//  read from a single-read-port RAM. Reset: a clearing pass zeroes the value
//  table and list starts; busy stays high meanwhile. Config writes are taken
//  at any time. The receiver cannot stall results; a two-beat command queue
//  lets the sender run ahead of the sequencer until it fills, then busy rises.
//
`default_nettype none

module cnf_unit_propagation (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [2:0]              i_kind,
    input  wire logic [cup_pkg::VW-1:0]  i_var_index,
    input  wire logic                    i_negated,
    input  wire logic                    i_clause_end,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [cup_pkg::VW-1:0]  i_cfg_data,
    output logic                         o_done,
    output logic                         o_conflict,
    output logic [cup_pkg::CCW-1:0]      o_unsat_clauses,
    output logic [1:0]                   o_var_state,
    output logic [cup_pkg::CIW-1:0]      o_last_clause,
    output logic [1:0]                   o_status
);
    import cup_pkg::*;

    t_cmd       cmd;
    logic       cmd_valid;
    t_back_stat back_stat;

    // front end: range check and command queue
    cup_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_kind       (i_kind),
        .i_var_index  (i_var_index),
        .i_negated    (i_negated),
        .i_clause_end (i_clause_end),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_back       (back_stat),
        .o_busy       (busy),
        .o_cfg_ready  (o_cfg_ready),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    // back end: memories and propagation sequencer
    cup_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_stat          (back_stat),
        .o_done          (o_done),
        .o_conflict      (o_conflict),
        .o_unsat_clauses (o_unsat_clauses),
        .o_var_state     (o_var_state),
        .o_last_clause   (o_last_clause),
        .o_status        (o_status)
    );

endmodule

`default_nettype wire
